// ----- rtl/hpe_pkg.sv -----
// ----------------------------------------------------------------------------
// hpe_pkg: Horner polynomial evaluator shared types and constants
// Payload words, pipeline stage word and register map of the evaluator.
// ----------------------------------------------------------------------------
package hpe_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned PROD_W     = 2 * DATA_W;
   localparam int unsigned Q_SHIFT    = 16;
   localparam int unsigned TERM_W     = 3;
   localparam int unsigned NUM_COEFS  = 7;
   localparam int unsigned COEF_IDX_W = 3;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FIRST = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAST  = 4'd7;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_value;
      logic                     last_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_value;
      logic                     last_out;
   } rsp_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic                     last;
   } stage_type;

endpackage

// ----- rtl/hpe_step.sv -----
// ----------------------------------------------------------------------------
// hpe_step: one Horner step
// Multiply stage (y*x, full 64 bits) then shift, add coefficient and saturate.
// An inactive step passes y through unchanged.
// ----------------------------------------------------------------------------
module hpe_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  hpe_pkg::stage_type               in_word,
   input  logic signed [hpe_pkg::DATA_W-1:0] coef,
   input  logic                             active,
   output logic                             out_valid,
   input  logic                             out_ready,
   output hpe_pkg::stage_type               out_word
);

   function automatic logic signed [hpe_pkg::DATA_W-1:0] sat_add(
      input logic signed [hpe_pkg::PROD_W-1:0] prod,
      input logic signed [hpe_pkg::DATA_W-1:0] c
   );
      logic signed [hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT:0] sum;
      logic signed [hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT:0] max_v;
      logic signed [hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT:0] min_v;
      sum   = (hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT+1)'(
                 $signed(prod[hpe_pkg::PROD_W-1:hpe_pkg::Q_SHIFT]))
            + (hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT+1)'(c);
      max_v = (hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT+1)'(
                 $signed({1'b0, {(hpe_pkg::DATA_W-1){1'b1}}}));
      min_v = (hpe_pkg::PROD_W-hpe_pkg::Q_SHIFT+1)'(
                 $signed({1'b1, {(hpe_pkg::DATA_W-1){1'b0}}}));
      if (sum > max_v) begin
         return max_v[hpe_pkg::DATA_W-1:0];
      end else if (sum < min_v) begin
         return min_v[hpe_pkg::DATA_W-1:0];
      end
      return sum[hpe_pkg::DATA_W-1:0];
   endfunction

   logic                              m_valid_ff, m_valid_in;
   hpe_pkg::stage_type                m_word_ff;
   logic signed [hpe_pkg::PROD_W-1:0] m_prod_ff, m_prod_in;
   logic                              a_valid_ff, a_valid_in;
   hpe_pkg::stage_type                a_word_ff, a_word_in;
   logic                              a_ready, m_ready, m_load, a_load;

   assign a_ready  = !a_valid_ff || out_ready;
   assign m_ready  = !m_valid_ff || a_ready;
   assign m_load   = in_valid && m_ready;
   assign a_load   = m_valid_ff && a_ready;
   assign in_ready = m_ready;

   assign m_valid_in = m_ready ? in_valid : m_valid_ff;
   assign a_valid_in = a_ready ? m_valid_ff : a_valid_ff;
   assign m_prod_in  = $signed(in_word.y) * $signed(in_word.x);

   always_comb begin
      a_word_in      = m_word_ff;
      if (active) begin
         a_word_in.y = sat_add(m_prod_ff, coef);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_word_ff <= in_word;
         m_prod_ff <= m_prod_in;
      end
      if (a_load) begin
         a_word_ff <= a_word_in;
      end
   end

   assign out_valid = a_valid_ff;
   assign out_word  = a_word_ff;

   // bypassed step keeps y
   a_bypass_keeps_y: assert property (@(posedge clock) disable iff (reset)
      a_load && !active |=> a_word_ff.y == $past(m_word_ff.y))
      else $error("inactive step altered y");

   a_sideband_kept: assert property (@(posedge clock) disable iff (reset)
      a_load |=> a_word_ff.x == $past(m_word_ff.x) && a_word_ff.last == $past(m_word_ff.last))
      else $error("x or last lost across add stage");

   a_mult_hold: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && !a_ready |=> m_valid_ff && $stable(m_prod_ff) && $stable(m_word_ff))
      else $error("blocked multiply stage changed");

endmodule

// ----- rtl/horner_polynomial_eval.sv -----
// Path to rsp_valid: input stage register, then multiply and add registers of each step.
// Throughput: one word per cycle; each Horner step is a multiply stage and an add stage.
// Stalls back up stage by stage; empty stages are filled while the output waits.
// Reset (synchronous): pipeline emptied, term_count = 1, all coefficients 0.
// ----------------------------------------------------------------------------
// horner_polynomial_eval: streaming Horner polynomial evaluator
// Evaluates y = coef_0, y = sat(y*x >>> 16 + coef_j) per sample in Q16.16.
// ----------------------------------------------------------------------------
module horner_polynomial_eval #(
   parameter int unsigned MAX_TERMS = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hpe_pkg::req_word_type              req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hpe_pkg::rsp_word_type              rsp_word,
   input  logic                               csr_write_en,
   input  logic [hpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hpe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [hpe_pkg::TERM_W-1:0]         term_count_ff;
   logic signed [hpe_pkg::DATA_W-1:0]  coef_ff [hpe_pkg::NUM_COEFS];
   logic [hpe_pkg::TERM_W-1:0]         terms_eff;
   logic [hpe_pkg::COEF_IDX_W-1:0]     coef_idx;

   logic                               s0_valid_ff, s0_valid_in, s0_ready;
   hpe_pkg::stage_type                 s0_word_ff, s0_word_in;

   logic                               link_valid [MAX_TERMS];
   logic                               link_ready [MAX_TERMS];
   hpe_pkg::stage_type                 link_word  [MAX_TERMS];

   // register writes
   assign coef_idx = hpe_pkg::COEF_IDX_W'(csr_index - hpe_pkg::CSR_COEF_FIRST);

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= hpe_pkg::TERM_W'(1);
         for (int k = 0; k < hpe_pkg::NUM_COEFS; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            hpe_pkg::CSR_TERM_COUNT: begin
               term_count_ff <= csr_wdata[hpe_pkg::TERM_W-1:0];
            end
            default: begin
               if (csr_index inside {[hpe_pkg::CSR_COEF_FIRST:hpe_pkg::CSR_COEF_LAST]}) begin
                  coef_ff[coef_idx] <= csr_wdata[hpe_pkg::DATA_W-1:0];
               end
            end
         endcase
      end
   end

   always_comb begin
      terms_eff = term_count_ff;
      if (terms_eff == '0) begin
         terms_eff = hpe_pkg::TERM_W'(1);
      end
      if (terms_eff > hpe_pkg::TERM_W'(MAX_TERMS)) begin
         terms_eff = hpe_pkg::TERM_W'(MAX_TERMS);
      end
   end

   // input stage: y starts at coef_0
   assign s0_ready    = !s0_valid_ff || link_ready[0];
   assign req_stall   = !s0_ready;
   assign s0_valid_in = s0_ready ? req_valid : s0_valid_ff;

   always_comb begin
      s0_word_in.x    = req_word.x_value;
      s0_word_in.y    = coef_ff[0];
      s0_word_in.last = req_word.last_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s0_ready) begin
         s0_word_ff <= s0_word_in;
      end
   end

   assign link_valid[0] = s0_valid_ff;
   assign link_word[0]  = s0_word_ff;

   for (genvar j = 1; j < MAX_TERMS; j++) begin : g_step
      hpe_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[j-1]),
         .in_ready  (link_ready[j-1]),
         .in_word   (link_word[j-1]),
         .coef      (coef_ff[j]),
         .active    (hpe_pkg::TERM_W'(j) < terms_eff),
         .out_valid (link_valid[j]),
         .out_ready (link_ready[j]),
         .out_word  (link_word[j])
      );
   end

   assign link_ready[MAX_TERMS-1] = !rsp_stall;
   assign rsp_valid               = link_valid[MAX_TERMS-1];
   assign rsp_word.y_value        = link_word[MAX_TERMS-1].y;
   assign rsp_word.last_out       = link_word[MAX_TERMS-1].last;

endmodule

// ----- tb/tb_horner_polynomial_eval.sv -----
// ----------------------------------------------------------------------------
// tb_horner_polynomial_eval: self-checking bench for the Horner evaluator
// Loads coefficient sets through the register port and streams Q16.16
// samples. Every sample is evaluated by a behavioral Horner model, and each
// result word is compared in order. Random idling, a long output hold-off
// and full-rate traffic are exercised.
// ----------------------------------------------------------------------------
module tb_horner_polynomial_eval;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PIPE_LATENCY = 13;
   localparam int unsigned MAX_SHOWN    = 10;
   localparam longint      SAT_HI       = 64'sd2147483647;
   localparam longint      SAT_LO       = -64'sd2147483648;
   localparam logic signed [hpe_pkg::DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [hpe_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [hpe_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   logic                           req_stall;
   hpe_pkg::req_word_type          req_word     = '0;
   logic                           rsp_valid;
   logic                           rsp_stall    = 1'b0;
   hpe_pkg::rsp_word_type          rsp_word;
   logic                           csr_write_en = 1'b0;
   logic [hpe_pkg::CSR_IDX_W-1:0]  csr_index    = '0;
   logic [hpe_pkg::CSR_DATA_W-1:0] csr_wdata    = '0;

   logic [hpe_pkg::TERM_W-1:0]        poly_terms = 3'd1;
   logic signed [hpe_pkg::DATA_W-1:0] poly_coef [hpe_pkg::NUM_COEFS] = '{default: '0};

   hpe_pkg::rsp_word_type pending_y [$];
   int unsigned  mismatch_count  = 0;
   int unsigned  cycle_count     = 0;
   bit           req_idle_on     = 1'b1;
   bit           rsp_idle_on     = 1'b1;
   int unsigned  hold_rsp_cycles = 0;

   horner_polynomial_eval dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic signed [hpe_pkg::DATA_W-1:0] horner_expected(
      input logic signed [hpe_pkg::DATA_W-1:0] x);
      int unsigned n;
      int unsigned j;
      longint      acc;
      longint      prod;
      n   = (poly_terms == 0) ? 1 : 32'(poly_terms);
      acc = longint'(poly_coef[0]);
      for (j = 1; j < n; j++) begin
         prod = acc * longint'(x);
         acc  = (prod >>> hpe_pkg::Q_SHIFT) + longint'(poly_coef[j]);
         if (acc > SAT_HI) begin
            acc = SAT_HI;
         end else if (acc < SAT_LO) begin
            acc = SAT_LO;
         end
      end
      return acc[hpe_pkg::DATA_W-1:0];
   endfunction

   function automatic logic signed [hpe_pkg::DATA_W-1:0] rand_q16(input int unsigned span);
      logic signed [hpe_pkg::DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            v = $urandom;
         end
         9: begin
            case ($urandom_range(0, 4))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = '0;
               3: v = Q_ONE;
               default: v = -Q_ONE;
            endcase
         end
         default: begin
            v = $urandom_range(0, 2 * span) - span;
         end
      endcase
      return v;
   endfunction

   task automatic csr_write(input logic [hpe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hpe_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == hpe_pkg::CSR_TERM_COUNT) begin
         poly_terms = data[hpe_pkg::TERM_W-1:0];
      end else if (idx >= hpe_pkg::CSR_COEF_FIRST && idx <= hpe_pkg::CSR_COEF_LAST) begin
         poly_coef[hpe_pkg::COEF_IDX_W'(idx - hpe_pkg::CSR_COEF_FIRST)] = data;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_y.size() != 0) @(posedge clock);
   endtask

   task automatic load_poly(input int unsigned terms,
                            input logic signed [hpe_pkg::DATA_W-1:0] c [hpe_pkg::NUM_COEFS]);
      int unsigned k;
      wait_idle();
      csr_write(hpe_pkg::CSR_TERM_COUNT, ($urandom & ~32'h7) | terms);
      for (k = 0; k < hpe_pkg::NUM_COEFS; k++) begin
         csr_write(hpe_pkg::CSR_IDX_W'(hpe_pkg::CSR_COEF_FIRST + k), c[k]);
      end
   endtask

   task automatic load_random_poly(input int unsigned terms, input int unsigned span);
      logic signed [hpe_pkg::DATA_W-1:0] c [hpe_pkg::NUM_COEFS];
      int unsigned k;
      for (k = 0; k < hpe_pkg::NUM_COEFS; k++) begin
         c[k] = rand_q16(span);
      end
      load_poly(terms, c);
   endtask

   task automatic send_sample(input logic signed [hpe_pkg::DATA_W-1:0] x, input logic last);
      hpe_pkg::req_word_type w;
      hpe_pkg::rsp_word_type want;
      w.x_value     = x;
      w.last_sample = last;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      want.y_value  = horner_expected(x);
      want.last_out = last;
      pending_y.push_back(want);
   endtask

   task automatic feed_sample(input logic signed [hpe_pkg::DATA_W-1:0] x, input logic last);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      send_sample(x, last);
   endtask

   task automatic feed_random(input int unsigned count, input int unsigned span);
      int unsigned k;
      for (k = 0; k < count; k++) begin
         feed_sample(rand_q16(span), $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_reset_state();
      send_sample(Q_MAX, 1'b1);
      send_sample(Q_MIN, 1'b0);
      send_sample($urandom, 1'b1);
   endtask

   task automatic test_known_poly();
      // 2x^2 + 3x + 1
      load_poly(3, '{32'sh0002_0000, 32'sh0003_0000, Q_ONE, 0, 0, 0, 0});
      send_sample(32'sh0002_0000, 1'b0);
      send_sample(32'shffff_8000, 1'b1);
   endtask

   task automatic test_extremes();
      load_poly(7, '{default: Q_MAX});
      send_sample(Q_MAX, 1'b0);
      send_sample(Q_MIN, 1'b1);
      send_sample('0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(Q_ONE, 1'b1);
      load_poly(7, '{default: Q_MIN});
      send_sample(Q_MAX, 1'b0);
      send_sample(Q_MIN, 1'b1);
      load_poly(7, '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX});
      send_sample(Q_ONE, 1'b0);
      send_sample(-Q_ONE, 1'b1);
   endtask

   task automatic test_zero_terms();
      // zero term count acts as a single term
      load_poly(0, '{32'sh0001_8000, Q_ONE, Q_MAX, Q_MIN, Q_ONE, Q_ONE, Q_ONE});
      send_sample(32'sh0004_0000, 1'b0);
      send_sample(Q_MIN, 1'b1);
   endtask

   task automatic test_ignored_index();
      int unsigned idx;
      load_random_poly(5, 32'h0002_0000);
      for (idx = hpe_pkg::CSR_COEF_LAST + 1; idx < (1 << hpe_pkg::CSR_IDX_W); idx++) begin
         csr_write(hpe_pkg::CSR_IDX_W'(idx), $urandom);
      end
      send_sample(Q_ONE, 1'b0);
      send_sample(32'shfffe_0000, 1'b1);
   endtask

   task automatic test_random_configs();
      int unsigned phase;
      int unsigned terms;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: terms = 7;
            1: terms = 1;
            2: terms = 0;
            default: terms = $urandom_range(0, 7);
         endcase
         load_random_poly(terms, $urandom_range(0, 1) ? 32'h0002_0000 : 32'h0000_8000);
         feed_random(55, 32'h0004_0000);
      end
   endtask

   task automatic test_output_backpressure();
      load_random_poly(7, 32'h0000_8000);
      req_idle_on     = 1'b0;
      hold_rsp_cycles = 300;
      feed_random(48, 32'h0002_0000);
      req_idle_on = 1'b1;
   endtask

   task automatic test_input_pause();
      load_random_poly($urandom_range(2, 7), 32'h0001_0000);
      feed_random(20, 32'h0004_0000);
      wait_idle();
      feed_random(20, 32'h0004_0000);
   endtask

   task automatic test_full_rate();
      load_random_poly(7, 32'h0000_8000);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      feed_random(100, 32'h0004_0000);
   endtask

   initial begin : rsp_stall_gen
      int unsigned n;
      forever begin
         if (hold_rsp_cycles != 0) begin
            n               = hold_rsp_cycles;
            hold_rsp_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      hpe_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_y.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
               $display("unexpected word: y=%h last=%b", rsp_word.y_value,
                        rsp_word.last_out);
            end
         end else begin
            want = pending_y.pop_front();
            if (rsp_word.y_value !== want.y_value ||
                rsp_word.last_out !== want.last_out) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN) begin
                  $display("word mismatch: expected y=%h last=%b, got y=%h last=%b",
                           want.y_value, want.last_out,
                           rsp_word.y_value, rsp_word.last_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("horner_polynomial_eval: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_known_poly();
      test_extremes();
      test_zero_terms();
      test_ignored_index();
      test_random_configs();
      test_output_backpressure();
      test_input_pause();
      test_full_rate();
      wait_idle();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_y.size() == 0) begin
         $display("horner_polynomial_eval: match");
      end else begin
         $display("horner_polynomial_eval: mismatch");
      end
      $finish;
   end

endmodule
